[hw/rtl/bdpc_pkg.sv]
`default_nettype none

package bdpc_pkg;

  // history ring depth used when the top level is not overridden
  localparam int unsigned HISTORY_DEPTH_DEF = 8;

  localparam int unsigned THR_W = 16;
  localparam int unsigned CNT_W = THR_W + 1;

  localparam logic [THR_W-1:0] SHORT_PRESS_RST = 16'd1000;
  localparam logic [THR_W-1:0] LONG_HOLD_RST   = 16'd10000;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD   = 8'd1;

  typedef enum logic [1:0] {
    ST_UNPRESSED = 2'd0,
    ST_PRESSED   = 2'd1,
    ST_HELD      = 2'd2
  } status_t;

  // history scan result handed to the sequencer
  typedef struct packed {
    logic       done;
    logic [1:0] down;
  } hist_stat_t;

endpackage

`default_nettype wire

[hw/rtl/button_debounce_press_classifier_unit.sv]
// Two-button debounce and press classifier, one input item per timer tick.
// An item carries the raw active-low pin levels; the block stores them in a
// ring of HISTORY_DEPTH samples and calls a button down only when every stored
// sample shows it pressed. Per button a 17-bit hold counter runs while down
// and stops at long_hold_ticks + 1; a hold past long_hold_ticks makes it HELD,
// a debounced release with short_press_ticks < count <= long_hold_ticks gives
// a one-tick press event. A hold event fires when a button newly becomes HELD
// and arms a shared acknowledge; the next press edge of either button returns
// that button to unpressed. Each item yields exactly one result item. No new
// item is taken while one is in work: the history ring is walked one entry
// a cycle through its single read port, then one shared 17-bit comparator
// runs three steps for each button, then the result is loaded. The result
// sits in an output register, so the next item is taken while it waits;
// only a second result stalls behind a full register.
// Threshold writes take effect at once and are always accepted.
`default_nettype none

module button_debounce_press_classifier_unit
  import bdpc_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input items
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [1:0] raw_button_pins
  // result items
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [15:0]               m_axis_tdata,   // [1:0] debounced_down,
                                                    // [2] press_event_one,
                                                    // [3] press_event_two,
                                                    // [4] hold_event,
                                                    // [6:5] button_one_status,
                                                    // [8:7] button_two_status
  // threshold register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INC,
    S_HCHK,
    S_EDGE,
    S_FINISH
  } state_t;

  state_t           state;
  logic [THR_W-1:0] short_thr;
  logic [THR_W-1:0] long_thr;

  logic [CNT_W-1:0] hold_cnt [2];
  status_t          status [2];
  status_t          prev_status [2];
  logic             held_ack;
  logic [1:0]       prev_down;
  logic [1:0]       down_r;
  logic [1:0]       change_r;
  logic             sel;          // button being worked on
  logic             within_long;  // count <= long_hold_ticks after this tick's count

  hist_stat_t       hist;
  logic             in_accept;
  logic             out_free;

  // shared compare unit
  logic [CNT_W-1:0] cmp_cnt;
  logic [CNT_W-1:0] cmp_thr;
  logic             cmp_gt;

  // end-of-tick classification
  status_t          st_fin [2];
  logic [1:0]       press_ev;
  logic             hold_ev;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // pins are active low, the history stores 1 for pressed
  bdpc_hist #(
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_accept),
    .wr_sample(~s_axis_tdata[1:0]),
    .stat     (hist)
  );

  // edge step compares against the short threshold, the others against long
  assign cmp_cnt = hold_cnt[sel];
  assign cmp_thr = (state == S_EDGE) ? {1'b0, short_thr} : {1'b0, long_thr};
  assign cmp_gt  = cmp_cnt > cmp_thr;

  always_comb begin
    hold_ev = 1'b0;
    for (int b = 0; b < 2; b++) begin
      press_ev[b] = (status[b] == ST_PRESSED);
      st_fin[b]   = press_ev[b] ? ST_UNPRESSED : status[b];
      if (st_fin[b] == ST_HELD && prev_status[b] != ST_HELD) begin
        hold_ev = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_thr <= SHORT_PRESS_RST;
      long_thr  <= LONG_HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SHORT_PRESS) begin
        short_thr <= cfg_data;
      end else if (cfg_index == CFG_LONG_HOLD) begin
        long_thr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      hold_cnt[0]   <= '0;
      hold_cnt[1]   <= '0;
      status[0]     <= ST_UNPRESSED;
      status[1]     <= ST_UNPRESSED;
      prev_status[0] <= ST_UNPRESSED;
      prev_status[1] <= ST_UNPRESSED;
      held_ack      <= 1'b0;
      prev_down     <= 2'b00;
      down_r        <= 2'b00;
      change_r      <= 2'b00;
      sel           <= 1'b0;
      within_long   <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hist.done) begin
            down_r    <= hist.down;
            change_r  <= hist.down ^ prev_down;
            prev_down <= hist.down;
            sel       <= 1'b0;
            state     <= S_INC;
          end
        end
        S_INC: begin
          // count while down, stop once past the long threshold
          if (down_r[sel] && !cmp_gt) begin
            hold_cnt[sel] <= hold_cnt[sel] + 1'b1;
          end
          state <= S_HCHK;
        end
        S_HCHK: begin
          within_long <= !cmp_gt;
          if (down_r[sel] && cmp_gt) begin
            status[sel] <= ST_HELD;
          end
          state <= S_EDGE;
        end
        S_EDGE: begin
          if (change_r[sel]) begin
            if (down_r[sel]) begin
              // press edge: restart the hold, an armed ack releases the button
              hold_cnt[sel] <= '0;
              if (held_ack) begin
                status[sel] <= ST_UNPRESSED;
                held_ack    <= 1'b0;
              end
            end else if (cmp_gt && within_long) begin
              status[sel] <= ST_PRESSED;
            end
          end
          if (sel) begin
            state <= S_FINISH;
          end else begin
            sel   <= 1'b1;
            state <= S_INC;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            for (int b = 0; b < 2; b++) begin
              status[b]      <= st_fin[b];
              prev_status[b] <= st_fin[b];
            end
            if (hold_ev) begin
              held_ack <= 1'b1;
            end
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'd0, st_fin[1], st_fin[0], hold_ev, press_ev[1],
                              press_ev[0], down_r};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bdpc_hist.sv]
`default_nettype none

module bdpc_hist
  import bdpc_pkg::*;
#(
  parameter int unsigned DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire logic [1:0] wr_sample,
  output hist_stat_t      stat
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(DEPTH);

  logic [1:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [IW-1:0]    wr_idx;
  logic [CW-1:0]    rd_cnt;
  logic             scanning;
  logic             rd_pend;
  logic [1:0]       rd_q;
  logic             rd_vld_q;
  logic [1:0]       acc;
  logic             done;
  logic             rd_go;
  logic [IW-1:0]    rd_addr;
  logic [1:0]       rd_data;

  assign rd_go   = scanning && (rd_cnt != CNT_END);
  assign rd_addr = rd_cnt[IW-1:0];
  // entries never written read as not pressed
  assign rd_data = rd_vld_q ? rd_q : 2'b00;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_sample;
    end
    if (rd_go) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      wr_idx   <= '0;
      rd_cnt   <= '0;
      scanning <= 1'b0;
      rd_pend  <= 1'b0;
      rd_vld_q <= 1'b0;
      acc      <= 2'b00;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        vld[wr_idx] <= 1'b1;
        wr_idx      <= (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;
        scanning    <= 1'b1;
        rd_cnt      <= '0;
        rd_pend     <= 1'b0;
        acc         <= 2'b11;
      end else if (scanning) begin
        rd_pend <= rd_go;
        if (rd_go) begin
          rd_vld_q <= vld[rd_addr];
          rd_cnt   <= rd_cnt + 1'b1;
        end
        if (rd_pend) begin
          acc <= acc & rd_data;
        end
        if (!rd_go && rd_pend) begin
          scanning <= 1'b0;
          done     <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.down = acc;

endmodule

`default_nettype wire

[hw/rtl/bdpc_checker.sv]
`default_nettype none

module bdpc_checker
  import bdpc_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [15:0]          m_axis_tdata
);

  // one item at a time: the block goes busy after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken on back-to-back cycles");

  // pressed is consumed within the tick and never shows
  a_no_pressed_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[6:5] != ST_PRESSED && m_axis_tdata[8:7] != ST_PRESSED))
    else $error("pressed status reported");

  // a press event completes on a debounced release
  a_press_on_release: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!(m_axis_tdata[2] && m_axis_tdata[0]) &&
                       !(m_axis_tdata[3] && m_axis_tdata[1])))
    else $error("press event while button down");

  // a hold event leaves at least one button held
  a_hold_has_held: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[4]) |->
      (m_axis_tdata[6:5] == ST_HELD || m_axis_tdata[8:7] == ST_HELD))
    else $error("hold event without held button");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind button_debounce_press_classifier_unit bdpc_checker u_bdpc_checker (.*);

`default_nettype wire
